// ----- hdl/lac_pkg.sv -----
// Shared types, constants and the loop classifier for the loop average block.
`timescale 1ns / 1ps
`default_nettype none

package lac_pkg;

    localparam int SAMPLES_LOG2 = 4;
    localparam int NUM_LOOPS    = 4;

    localparam int RAW_W   = 12;
    localparam int MV_W    = 12;
    localparam int ACC_W   = MV_W + SAMPLES_LOG2;
    localparam int CNT_W   = (SAMPLES_LOG2 > 0) ? SAMPLES_LOG2 : 1;
    localparam int CH_W    = (NUM_LOOPS > 1) ? $clog2(NUM_LOOPS) : 1;
    localparam int SAMPLES = 1 << SAMPLES_LOG2;
    localparam int OUT_LOOPS = 4;

    // raw * 804 / 1000 as a multiply by 0.804 * 2^24, rounded up, then shift.
    // The error stays below 1e-4 over all 12-bit inputs, while the true
    // fraction never exceeds 0.996, so the floor is exact.
    localparam int             SCALE_SHIFT = 24;
    localparam logic [23:0]    SCALE_RECIP = 24'd13488882;
    localparam int             PROD_W      = RAW_W + SCALE_SHIFT;

    localparam logic [11:0] BREAK_RST  = 12'd200;
    localparam logic [11:0] CLOSED_RST = 12'd1000;
    localparam logic [11:0] SHORT_RST  = 12'd2500;

    typedef enum logic [1:0] {
        REG_BREAK  = 2'd0,
        REG_CLOSED = 2'd1,
        REG_SHORT  = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_OPEN   = 2'd0,
        ST_CLOSED = 2'd1,
        ST_BREAK  = 2'd2,
        ST_SHORT  = 2'd3
    } loop_state_t;

    typedef struct packed {
        logic [11:0] break_below;
        logic [11:0] closed_from;
        logic [11:0] short_above;
    } thresh_t;

    typedef struct packed {
        logic [3:0]                    kinds;
        loop_state_t [OUT_LOOPS-1:0]   loop_st;
        logic                          states_valid;
        logic [MV_W-1:0]               average_mv;
        logic [1:0]                    average_channel;
        logic                          average_valid;
        logic [1:0]                    sample_channel;
    } result_t;

    function automatic loop_state_t lac_classify(logic [MV_W-1:0] v, thresh_t t);
        loop_state_t s;
        if (v >= t.break_below && v < t.closed_from)
            s = ST_OPEN;
        else if (v >= t.closed_from && v <= t.short_above)
            s = ST_CLOSED;
        else if (v < t.break_below)
            s = ST_BREAK;
        else
            s = ST_SHORT;
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lac_cfg.sv -----
// APB register file holding the three classification thresholds.
`timescale 1ns / 1ps
`default_nettype none

module lac_cfg
    import lac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output thresh_t          thresh
);

    thresh_t    thresh_reg;
    logic       wr_en;
    reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_index_t'(paddr[3:2]);
    assign thresh = thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.break_below <= BREAK_RST;
            thresh_reg.closed_from <= CLOSED_RST;
            thresh_reg.short_above <= SHORT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BREAK:  thresh_reg.break_below <= pwdata[11:0];
                REG_CLOSED: thresh_reg.closed_from <= pwdata[11:0];
                REG_SHORT:  thresh_reg.short_above <= pwdata[11:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BREAK:  prdata = {20'd0, thresh_reg.break_below};
            REG_CLOSED: prdata = {20'd0, thresh_reg.closed_from};
            REG_SHORT:  prdata = {20'd0, thresh_reg.short_above};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/lac_scale.sv -----
// Input register and millivolt scaling stage.
`timescale 1ns / 1ps
`default_nettype none

module lac_scale
    import lac_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [RAW_W-1:0] in_raw,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [MV_W-1:0]       out_mv
);

    logic              a_valid_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic              b_valid_reg;
    logic [MV_W-1:0]   mv_reg;
    logic              a_adv;
    logic              b_adv;
    logic [PROD_W-1:0] prod;
    logic [MV_W-1:0]   mv_next;

    // each stage moves when the one after it is empty or moving
    assign b_adv    = !b_valid_reg || out_ready;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;

    assign prod    = PROD_W'(raw_reg) * PROD_W'(SCALE_RECIP);
    assign mv_next = prod[SCALE_SHIFT +: MV_W];

    assign out_valid = b_valid_reg;
    assign out_mv    = mv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_valid_reg <= in_valid;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_valid)
            raw_reg <= in_raw;
        if (b_adv && a_valid_reg)
            mv_reg <= mv_next;
    end

endmodule

`default_nettype wire

// ----- hdl/lac_avg.sv -----
// Accumulate, per-channel average, loop classification and result register.
`timescale 1ns / 1ps
`default_nettype none

module lac_avg
    import lac_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire thresh_t         thresh,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [MV_W-1:0] in_mv,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output result_t              out_res
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [MV_W-1:0]  avg_reg  [NUM_LOOPS];
    logic [MV_W-1:0]  avg_next [NUM_LOOPS];
    loop_state_t      st_reg   [NUM_LOOPS];
    loop_state_t      st_next  [NUM_LOOPS];
    logic             ovalid_reg;
    result_t          res_reg, res_next;
    logic             fire;
    logic [ACC_W-1:0] acc_sum;
    logic [MV_W-1:0]  avg_new;
    logic             done;
    logic             last;

    assign in_ready  = !ovalid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;

    assign acc_sum = acc_reg + ACC_W'(in_mv);
    assign avg_new = acc_sum[ACC_W-1 -: MV_W];
    assign done    = (cnt_reg == CNT_W'(SAMPLES - 1));
    assign last    = (ch_reg == CH_W'(NUM_LOOPS - 1));

    always_comb
    begin
        acc_next = done ? '0 : acc_sum;
        cnt_next = done ? '0 : cnt_reg + CNT_W'(1);
        if (done)
            ch_next = last ? '0 : ch_reg + CH_W'(1);
        else
            ch_next = ch_reg;

        for (int i = 0; i < NUM_LOOPS; i++)
        begin
            avg_next[i] = (done && ch_reg == CH_W'(i)) ? avg_new : avg_reg[i];
        end
        // a full round reclassifies every loop, including the one just done
        for (int i = 0; i < NUM_LOOPS; i++)
        begin
            st_next[i] = (done && last) ? lac_classify(avg_next[i], thresh) : st_reg[i];
        end
    end

    always_comb
    begin
        res_next                 = '0;
        res_next.sample_channel  = 2'(ch_next);
        res_next.average_valid   = done;
        res_next.average_channel = done ? 2'(ch_reg) : 2'd0;
        res_next.average_mv      = done ? avg_new : '0;
        res_next.states_valid    = done && last;
        for (int i = 0; i < OUT_LOOPS; i++)
        begin
            res_next.loop_st[i] = ST_OPEN;
        end
        for (int i = 0; i < NUM_LOOPS; i++)
        begin
            if (i < OUT_LOOPS)
                res_next.loop_st[i] = st_next[i];
            res_next.kinds[st_next[i]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            ch_reg     <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < NUM_LOOPS; i++)
            begin
                avg_reg[i] <= '0;
                st_reg[i]  <= ST_OPEN;
            end
        end
        else
        begin
            if (in_ready)
                ovalid_reg <= in_valid;
            if (fire)
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
                ch_reg  <= ch_next;
                for (int i = 0; i < NUM_LOOPS; i++)
                begin
                    avg_reg[i] <= avg_next[i];
                    st_reg[i]  <= st_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ----- hdl/loop_average_and_line_classify.sv -----
// Top level: alarm loop sample averaging and line state classification.
//
//  channel   dir  payload                                        transaction
//  s_axis    in   tdata[11:0] raw sample                         tvalid & tready
//  m_axis    out  tdata: channel, average, loop states, kinds    tvalid & tready
//                 tuser: average_valid, states_valid
//  apb       in   thresholds at 0x0, 0x4, 0x8 (12 bits each)     psel & penable & pready
//
// One sample per cycle sustained while m_axis is not stalled; a sample's result
// passes the input register, the scaling multiplier register, then the
// accumulate/classify result register before it appears on m_axis.
// Reset clears the pipeline, accumulator, sample count, channel, averages and
// loop states, and loads thresholds 200 / 1000 / 2500 mV.
// With m_axis_tready low the output holds; up to three samples queue in the
// pipeline before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module loop_average_and_line_classify
    import lac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [11:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] sample_channel, [3:2] average_channel, [15:4] average_mv,
    // [17:16] loop0_state, [19:18] loop1_state, [21:20] loop2_state,
    // [23:22] loop3_state, [27:24] kinds_present, [31:28] zero
    output logic [31:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,  // [0] average_valid, [1] states_valid
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    thresh_t         thresh;
    logic            mv_valid;
    logic            mv_ready;
    logic [MV_W-1:0] mv;
    result_t         res;

    lac_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thresh  (thresh)
    );

    lac_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_raw    (s_axis_tdata[RAW_W-1:0]),
        .out_valid (mv_valid),
        .out_ready (mv_ready),
        .out_mv    (mv)
    );

    lac_avg u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .thresh    (thresh),
        .in_valid  (mv_valid),
        .in_ready  (mv_ready),
        .in_mv     (mv),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {4'd0, res.kinds,
                           res.loop_st[3], res.loop_st[2], res.loop_st[1], res.loop_st[0],
                           res.average_mv, res.average_channel, res.sample_channel};
    assign m_axis_tuser = {res.states_valid, res.average_valid};

    // a full round only completes on the last channel and wraps back to channel 0
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[0] && m_axis_tdata[3:2] == 2'(NUM_LOOPS - 1)
            && m_axis_tdata[1:0] == 2'd0)
        else $error("states update without a completed last channel");

    // every loop has some state, so the kinds mask is never empty
    a_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[27:24] != 4'd0)
        else $error("empty kinds_present mask");

    a_avg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[15:4] == 12'd0 && m_axis_tdata[3:2] == 2'd0)
        else $error("average fields set without a completed average");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:4] <= 12'd3292)
        else $error("average above full-scale millivolts");

endmodule

`default_nettype wire
